// ----- design/att_pkg.sv -----
// Shared types and constants of the alarm timer table.
package att_pkg;

    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_REGISTER = 2'd1;
    localparam logic [1:0] ACT_CANCEL   = 2'd2;
    localparam logic [1:0] ACT_UNUSED   = 2'd3;

    localparam logic [2:0] KIND_FIRED      = 3'd0;
    localparam logic [2:0] KIND_NONE       = 3'd1;
    localparam logic [2:0] KIND_REGISTERED = 3'd2;
    localparam logic [2:0] KIND_FULL       = 3'd3;
    localparam logic [2:0] KIND_CANCELLED  = 3'd4;

    localparam int         MAX_OUT  = 16;
    localparam int         FW       = $clog2(MAX_OUT + 1);
    localparam logic [4:0] CNT_MAX  = 5'd31;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic run;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_status;

endpackage

// ----- design/att_ctrl.sv -----
// Sequencing state machine of the alarm timer table.
module att_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic [1:0]     i_action,
    input  att_pkg::t_status i_status,
    output att_pkg::t_cmd  o_cmd,
    output logic           busy
);
    import att_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_go;

    assign w_go = start && (i_action != ACT_UNUSED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_go) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = w_go;
            end
            S_SCAN: begin
                o_cmd.run = 1'b1;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ----- design/att_dp.sv -----
// Slot storage, scan pipeline and result register of the alarm timer table.
module att_dp #(
    parameter int SLOTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  att_pkg::t_cmd    i_cmd,
    output att_pkg::t_status o_status,
    input  logic [1:0]       i_action,
    input  logic [31:0]      i_now_time,
    input  logic [15:0]      i_task_id,
    input  logic [23:0]      i_delay,
    input  logic             i_repeat_req,
    output logic             o_strobe,
    output logic [2:0]       o_kind,
    output logic [15:0]      o_fired_id,
    output logic [3:0]       o_slot,
    output logic [4:0]       o_cancel_count,
    output logic             o_last
);
    import att_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
    localparam logic [CW-1:0] SLOT_CNT = CW'(SLOTS);
    localparam logic [FW-1:0] FIRE_LIM = FW'(MAX_OUT - 1);

    logic [15:0] mem_id  [SLOTS];
    logic [31:0] mem_dl  [SLOTS];
    logic [23:0] mem_per [SLOTS];
    logic        mem_rel [SLOTS];
    logic        r_valid [SLOTS];

    logic [1:0]    r_act;
    logic [31:0]   r_now;
    logic [15:0]   r_id;
    logic [23:0]   r_delay;
    logic          r_rep;

    logic [CW-1:0] r_rd_cnt;
    logic [IW-1:0] w_rd_idx;
    logic          w_rd_go;
    logic          r_ev_vld;
    logic [IW-1:0] r_ev_idx;
    logic [15:0]   r_q_id;
    logic [31:0]   r_q_dl;
    logic [23:0]   r_q_per;
    logic          r_q_rel;

    logic          r_pend;
    logic [15:0]   r_pend_id;
    logic [IW-1:0] r_pend_slot;
    logic [FW-1:0] r_nfire;
    logic [4:0]    r_cnt;

    logic          w_eval;
    logic          w_live;
    logic          w_fire;
    logic          w_take;
    logic          w_hit;
    logic [23:0]   w_addend;
    logic [32:0]   w_sum;
    logic [31:0]   w_sat;

    assign w_rd_idx = r_rd_cnt[IW-1:0];
    assign w_rd_go  = i_cmd.run && (r_rd_cnt < SLOT_CNT);
    assign w_eval   = i_cmd.run && r_ev_vld;
    assign w_live   = r_valid[r_ev_idx];
    assign w_fire   = w_eval && (r_act == ACT_TICK) && w_live && (r_q_dl <= r_now);
    assign w_take   = w_eval && (r_act == ACT_REGISTER) && !w_live;
    assign w_hit    = w_eval && (r_act == ACT_CANCEL) && w_live && (r_q_id == r_id);

    assign w_addend = (r_act == ACT_REGISTER) ? r_delay : r_q_per;
    assign w_sum    = {1'b0, r_now} + {9'd0, w_addend};
    assign w_sat    = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];

    assign o_status.done = r_ev_vld && ((r_ev_idx == LAST_IDX) || w_take ||
                           (w_fire && (r_nfire == FIRE_LIM)));

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            mem_id[r_ev_idx]  <= r_id;
            mem_per[r_ev_idx] <= r_delay;
            mem_rel[r_ev_idx] <= r_rep;
        end
        if (w_take || (w_fire && r_q_rel)) begin
            mem_dl[r_ev_idx] <= w_sat;
        end
        if (w_rd_go) begin
            r_q_id  <= mem_id[w_rd_idx];
            r_q_dl  <= mem_dl[w_rd_idx];
            r_q_per <= mem_per[w_rd_idx];
            r_q_rel <= mem_rel[w_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (w_take) begin
            r_valid[r_ev_idx] <= 1'b1;
        end else if (w_hit || (w_fire && !r_q_rel)) begin
            r_valid[r_ev_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act   <= i_action;
            r_now   <= i_now_time;
            r_id    <= i_task_id;
            r_delay <= i_delay;
            r_rep   <= i_repeat_req;
        end
        if (w_rd_go) begin
            r_ev_idx <= w_rd_idx;
        end
        if (w_fire) begin
            r_pend_id   <= r_q_id;
            r_pend_slot <= r_ev_idx;
        end else if (w_take) begin
            r_pend_id   <= r_id;
            r_pend_slot <= r_ev_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_cnt <= '0;
            r_ev_vld <= 1'b0;
            r_pend   <= 1'b0;
            r_nfire  <= '0;
            r_cnt    <= '0;
        end else if (i_cmd.load) begin
            r_rd_cnt <= '0;
            r_ev_vld <= 1'b0;
            r_pend   <= 1'b0;
            r_nfire  <= '0;
            r_cnt    <= '0;
        end else begin
            r_ev_vld <= w_rd_go;
            if (w_rd_go) begin
                r_rd_cnt <= r_rd_cnt + CW'(1);
            end
            if (w_fire || w_take) begin
                r_pend <= 1'b1;
            end
            if (w_fire) begin
                r_nfire <= r_nfire + FW'(1);
            end
            if (w_hit && (r_cnt != CNT_MAX)) begin
                r_cnt <= r_cnt + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= (w_fire && r_pend) || i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        o_kind         <= KIND_FIRED;
        o_fired_id     <= r_pend_id;
        o_slot         <= 4'(r_pend_slot);
        o_cancel_count <= 5'd0;
        o_last         <= i_cmd.finish;
        if (i_cmd.finish) begin
            case (r_act)
                ACT_TICK: begin
                    if (!r_pend) begin
                        o_kind     <= KIND_NONE;
                        o_fired_id <= 16'd0;
                        o_slot     <= 4'd0;
                    end
                end
                ACT_REGISTER: begin
                    if (r_pend) begin
                        o_kind <= KIND_REGISTERED;
                    end else begin
                        o_kind     <= KIND_FULL;
                        o_fired_id <= 16'd0;
                        o_slot     <= 4'd0;
                    end
                end
                default: begin
                    o_kind         <= KIND_CANCELLED;
                    o_fired_id     <= 16'd0;
                    o_slot         <= 4'd0;
                    o_cancel_count <= r_cnt;
                end
            endcase
        end
    end

endmodule

// ----- design/alarm_timer_table_top.sv -----
// Top level of the alarm timer table: a table of one-shot and periodic alarm slots.
//
// A transaction is accepted on a rising edge with start high and busy low. The action selects
// a tick (fire every due slot), a register (store an alarm in the lowest free slot) or a
// cancel (free every slot holding the id). Action code 3 is dropped without a result.
// Results leave on o_strobe, one per cycle, and are taken at the end of that cycle; the
// receiver cannot hold them off. The final result of a transaction carries o_last.
// A tick gives one result per fired slot, at most 16, or a single none-due result.
// Register and cancel give exactly one result.
// Every transaction sweeps the slots once through a two-port slot memory with a
// registered read, one slot per cycle: a load step in idle, then the scan and a finish step,
// after which the final result leaves through the registered outputs. A register ends its
// sweep at the first free slot and a tick at its 16th firing.
// busy is high from the cycle after acceptance until the final result is issued, and the
// next transaction may be accepted in the cycle that shows the final result.
// Reset empties the table at once through per-slot valid flags and returns to idle.
module alarm_timer_table_top #(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_now_time,
    input  logic [15:0] i_task_id,
    input  logic [23:0] i_delay,
    input  logic        i_repeat_req,
    output logic        o_strobe,
    output logic [2:0]  o_kind,
    output logic [15:0] o_fired_id,
    output logic [3:0]  o_slot,
    output logic [4:0]  o_cancel_count,
    output logic        o_last
);
    import att_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    att_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .busy     (busy)
    );

    att_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_action       (i_action),
        .i_now_time     (i_now_time),
        .i_task_id      (i_task_id),
        .i_delay        (i_delay),
        .i_repeat_req   (i_repeat_req),
        .o_strobe       (o_strobe),
        .o_kind         (o_kind),
        .o_fired_id     (o_fired_id),
        .o_slot         (o_slot),
        .o_cancel_count (o_cancel_count),
        .o_last         (o_last)
    );

    a_strobe_in_txn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("Result issued outside a transaction.");

    a_quiet_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("Result issued right after the final result.");

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_kind != KIND_FIRED)) |-> o_last)
        else $error("Single-result transaction not marked last.");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action != ACT_UNUSED)) |=> busy)
        else $error("Accepted transaction did not raise busy.");

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the alarm timer table, with directed and random transactions.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import att_pkg::*;

    localparam int SLOTS          = 16;
    localparam int RANDOM_ITEMS   = 250;
    localparam int CALM_TAIL      = 40;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] fired_id;
        logic [3:0]  slot;
        logic [4:0]  cancel_count;
        logic        last;
    } t_alarm_result;

    class alarm_table_tracker;
        bit            armed [SLOTS];
        logic [15:0]   owner [SLOTS];
        logic [31:0]   deadline [SLOTS];
        logic [23:0]   period [SLOTS];
        bit            reload [SLOTS];
        t_alarm_result pending_results [$];
        int            failures;

        function void flag(string msg);
            failures++;
            if (failures <= REPORT_LIMIT) begin
                $display("%0t: %s", $time, msg);
            end
        endfunction

        function logic [31:0] later_by(logic [31:0] now, logic [23:0] span);
            logic [32:0] sum;
            sum = {1'b0, now} + {9'd0, span};
            return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        endfunction

        function void queue_result(logic [2:0] kind, logic [15:0] id, logic [3:0] slot,
                                   logic [4:0] count, logic last);
            t_alarm_result r;
            r.kind         = kind;
            r.fired_id     = id;
            r.slot         = slot;
            r.cancel_count = count;
            r.last         = last;
            pending_results.push_back(r);
        endfunction

        function void note_transaction(logic [1:0] action, logic [31:0] now, logic [15:0] id,
                                       logic [23:0] span, logic rep);
            int            fired;
            bit            placed;
            logic [4:0]    freed;
            t_alarm_result tail;
            fired  = 0;
            placed = 0;
            freed  = '0;
            case (action)
                ACT_TICK: begin
                    for (int i = 0; i < SLOTS && fired < MAX_OUT; i++) begin
                        if (armed[i] && deadline[i] <= now) begin
                            queue_result(KIND_FIRED, owner[i], 4'(i), 5'd0, 1'b0);
                            fired++;
                            if (reload[i]) begin
                                deadline[i] = later_by(now, period[i]);
                            end else begin
                                armed[i] = 0;
                            end
                        end
                    end
                    if (fired == 0) begin
                        queue_result(KIND_NONE, 16'd0, 4'd0, 5'd0, 1'b1);
                    end else begin
                        tail = pending_results.pop_back();
                        tail.last = 1'b1;
                        pending_results.push_back(tail);
                    end
                end
                ACT_REGISTER: begin
                    for (int i = 0; i < SLOTS && !placed; i++) begin
                        if (!armed[i]) begin
                            armed[i]    = 1;
                            owner[i]    = id;
                            deadline[i] = later_by(now, span);
                            period[i]   = span;
                            reload[i]   = rep;
                            placed      = 1;
                            queue_result(KIND_REGISTERED, id, 4'(i), 5'd0, 1'b1);
                        end
                    end
                    if (!placed) begin
                        queue_result(KIND_FULL, 16'd0, 4'd0, 5'd0, 1'b1);
                    end
                end
                ACT_CANCEL: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (armed[i] && owner[i] == id) begin
                            armed[i] = 0;
                            if (freed < CNT_MAX) begin
                                freed++;
                            end
                        end
                    end
                    queue_result(KIND_CANCELLED, 16'd0, 4'd0, freed, 1'b1);
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(t_alarm_result got);
            t_alarm_result want;
            if (pending_results.size() == 0) begin
                flag($sformatf("unexpected result: kind %0d id %h slot %0d count %0d last %0b",
                               got.kind, got.fired_id, got.slot, got.cancel_count, got.last));
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind) begin
                flag($sformatf("kind: expected %0d, got %0d", want.kind, got.kind));
            end
            if (got.fired_id !== want.fired_id) begin
                flag($sformatf("fired_id: expected %h, got %h", want.fired_id, got.fired_id));
            end
            if (got.slot !== want.slot) begin
                flag($sformatf("slot: expected %0d, got %0d", want.slot, got.slot));
            end
            if (got.cancel_count !== want.cancel_count) begin
                flag($sformatf("cancel_count: expected %0d, got %0d",
                               want.cancel_count, got.cancel_count));
            end
            if (got.last !== want.last) begin
                flag($sformatf("last: expected %0b, got %0b", want.last, got.last));
            end
        endfunction

        function void finish_check();
            if (pending_results.size() != 0) begin
                flag($sformatf("%0d expected results never arrived", pending_results.size()));
            end
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic        busy;
    logic [1:0]  i_action     = ACT_TICK;
    logic [31:0] i_now_time   = '0;
    logic [15:0] i_task_id    = '0;
    logic [23:0] i_delay      = '0;
    logic        i_repeat_req = 1'b0;
    logic        o_strobe;
    logic [2:0]  o_kind;
    logic [15:0] o_fired_id;
    logic [3:0]  o_slot;
    logic [4:0]  o_cancel_count;
    logic        o_last;

    alarm_table_tracker tracker = new;
    t_alarm_result      seen;
    int                 idle_cycles = 0;
    bit                 idle_phase  = 1;

    alarm_timer_table_top #(.SLOTS(SLOTS)) u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                seen = '{o_kind, o_fired_id, o_slot, o_cancel_count, o_last};
                tracker.check_result(seen);
            end
            if ((start && !busy) || o_strobe) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic int random_gap(bit calm);
        if (calm || !idle_phase || $urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(1, 3);
    endfunction

    task automatic send(input logic [1:0] action, input logic [31:0] now, input logic [15:0] id,
                        input logic [23:0] span, input logic rep, input int gap);
        int quiet;
        quiet = 0;
        if (gap > 0) begin
            start <= 1'b0;
            while (quiet < gap) begin
                @(posedge i_clk);
                if (!busy) begin
                    quiet++;
                end
            end
        end
        start        <= 1'b1;
        i_action     <= action;
        i_now_time   <= now;
        i_task_id    <= id;
        i_delay      <= span;
        i_repeat_req <= rep;
        do begin
            @(posedge i_clk);
        end while (busy);
        tracker.note_transaction(action, now, id, span, rep);
    endtask

    initial begin
        int          counted;
        int          roll;
        int          pick;
        bit          calm;
        logic [1:0]  action;
        logic [31:0] wall;
        logic [31:0] now;
        logic [15:0] id;
        logic [23:0] span;
        logic        rep;
        counted = 0;
        wall    = 32'd1000;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(ACT_TICK, 32'd0, 16'd0, 24'd0, 1'b0, random_gap(0));
        send(ACT_CANCEL, 32'd0, 16'hFFFF, 24'd0, 1'b0, random_gap(0));
        send(ACT_REGISTER, 32'hFFFF_FFFF, 16'hFFFF, 24'hFF_FFFF, 1'b1, random_gap(0));
        send(ACT_REGISTER, 32'd0, 16'd0, 24'd0, 1'b1, random_gap(0));
        send(ACT_TICK, 32'd0, 16'd0, 24'd0, 1'b0, random_gap(0));
        send(ACT_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 24'hFF_FFFF, 1'b1, random_gap(0));
        send(ACT_TICK, 32'hFFFF_FFFF, 16'd0, 24'd0, 1'b0, random_gap(0));
        send(ACT_CANCEL, 32'd0, 16'hFFFF, 24'd0, 1'b0, random_gap(0));
        send(ACT_CANCEL, 32'd0, 16'd0, 24'd0, 1'b0, random_gap(0));
        for (int i = 0; i < SLOTS; i++) begin
            send(ACT_REGISTER, 32'd200, 16'h00AA, 24'(i), 1'(i), random_gap(0));
        end
        send(ACT_REGISTER, 32'd200, 16'h0055, 24'd1, 1'b0, random_gap(0));
        send(ACT_TICK, 32'd300, 16'd0, 24'd0, 1'b0, random_gap(0));
        send(ACT_CANCEL, 32'd0, 16'h00AA, 24'd0, 1'b0, random_gap(0));

        while (counted < RANDOM_ITEMS) begin
            calm = counted >= RANDOM_ITEMS - CALM_TAIL;
            if ($urandom_range(0, 14) == 0) begin
                idle_phase = !idle_phase;
            end
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                action = ACT_UNUSED;
            end else if (roll < 48) begin
                action = ACT_REGISTER;
            end else if (roll < 84) begin
                action = ACT_TICK;
            end else begin
                action = ACT_CANCEL;
            end
            if ($urandom_range(0, 59) == 0) begin
                wall = 32'hFFFF_FF00 + 32'($urandom_range(0, 255));
            end
            if (action == ACT_TICK) begin
                wall = wall + 32'($urandom_range(0, 40));
            end
            now  = wall;
            id   = 16'($urandom_range(0, 7));
            span = 24'($urandom_range(0, 60));
            rep  = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) begin
                now = $urandom;
            end
            if ($urandom_range(0, 7) == 0) begin
                id = 16'($urandom);
            end
            if ($urandom_range(0, 9) == 0) begin
                span = 24'($urandom);
            end
            if (action == ACT_TICK && $urandom_range(0, 29) == 0) begin
                now = 32'hFFFF_FFFF;
            end
            if (action == ACT_CANCEL && $urandom_range(0, 1) == 0) begin
                pick = $urandom_range(0, SLOTS - 1);
                if (tracker.armed[pick]) begin
                    id = tracker.owner[pick];
                end
            end
            send(action, now, id, span, rep, random_gap(calm));
            if (action != ACT_UNUSED) begin
                counted++;
            end
        end
        start <= 1'b0;

        while (tracker.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        tracker.finish_check();
        if (tracker.failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/att_pkg.sv
design/att_ctrl.sv
design/att_dp.sv
design/alarm_timer_table_top.sv
bench/testbench.sv
